### src/cfdp_pkg.sv
`default_nettype none
package cfdp_pkg;

  localparam int HALF_ROWS    = 240;
  localparam int GROUPS       = 48;
  localparam int IMAGE_WORDS  = 10;
  localparam int INFO_WORDS   = 2;
  localparam int DARK_TOP     = 6;
  localparam int DARK_MID     = 7;
  localparam int DARK_BOTTOM  = 7;

  localparam int GROUP_WORDS  = IMAGE_WORDS + INFO_WORDS;
  localparam int IMAGE_WIDTH  = GROUPS * IMAGE_WORDS;
  localparam int TOTAL_ROWS   = DARK_TOP + HALF_ROWS + DARK_MID + HALF_ROWS + DARK_BOTTOM;
  localparam int BOTTOM_START = DARK_TOP + HALF_ROWS + DARK_MID;
  localparam int STORE_DEPTH  = 2 * HALF_ROWS * IMAGE_WIDTH;

  localparam int ADDR_W  = $clog2(STORE_DEPTH + 1);
  localparam int PIX_W   = 18;
  localparam int RAW_W   = 16;
  localparam int VAL_W   = 17;
  localparam int COORD_W = 9;
  localparam int ROW_W   = $clog2(TOTAL_ROWS + 1);
  localparam int POS_W   = $clog2(GROUP_WORDS);
  localparam int GRP_W   = $clog2(GROUPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIX_W-1:0] PED_OFFSET = PIX_W'(32'h10000);

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    CmdLoad,
    CmdPixel
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e              op;
    logic [ADDR_W-1:0]    addr;
    logic [PIX_W-1:0]     data;
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic                 last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

### src/ccd_frame_descramble_pedestal.sv
// CCD frame descrambler with per-pixel pedestal. Takes one word per cycle,
// sustained, as long as the output side keeps up; a pixel passes the command
// queue, the pedestal RAM read and the output register before it is presented,
// and the output side can stall it. The rate is set by the single pedestal RAM
// (230400 x 18, one write and one registered read port): each cycle it serves
// either one pedestal load or one pixel read. tuser marks loads (kind = 0) and
// frame words (kind = 1) and carries the start-of-frame / start-of-load flag.
// Unloaded store entries read as 0x10000 through a fill mark, so no clearing
// pass runs after reset and the block is ready at once.
`default_nettype none
module ccd_frame_descramble_pedestal
  import cfdp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value[16:0]
  input  wire logic [1:0]            s_axis_tuser,   // kind, first
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // pixel_value[17:0], column[8:0], row[8:0]
  output logic [0:0]                 m_axis_tuser,   // pedestal_applied
  output logic                       m_axis_tlast
);

  logic               use_ped_q;
  logic               push, pop;
  cmd_t               push_cmd, head_cmd;
  q_status_t          q_status;
  logic [PIX_W-1:0]   pixel_value;
  logic [COORD_W-1:0] column, row;
  logic               ped_applied;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_ped_q <= 1'b1;
    end else if (cfg_we_i) begin
      use_ped_q <= cfg_wdata_i;
    end
  end

  cfdp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .kind_i  (s_axis_tuser[0]),
    .value_i (s_axis_tdata[VAL_W-1:0]),
    .first_i (s_axis_tuser[1]),
    .full_i  (q_status.full),
    .push_o  (push),
    .cmd_o   (push_cmd)
  );

  cfdp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .cmd_i    (push_cmd),
    .pop_i    (pop),
    .status_o (q_status),
    .cmd_o    (head_cmd)
  );

  cfdp_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .use_pedestal_i     (use_ped_q),
    .q_valid_i          (q_status.valid),
    .cmd_i              (head_cmd),
    .pop_o              (pop),
    .valid_o            (m_axis_tvalid),
    .ready_i            (m_axis_tready),
    .pixel_value_o      (pixel_value),
    .column_o           (column),
    .row_o              (row),
    .pedestal_applied_o (ped_applied),
    .last_o             (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_DATA_W - PIX_W - 2 * COORD_W)'(0), row, column, pixel_value};
  assign m_axis_tuser = ped_applied;

endmodule
`default_nettype wire

### src/cfdp_ram.sv
`default_nettype none
module cfdp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/cfdp_front.sv
`default_nettype none
module cfdp_front
  import cfdp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  output logic                      ready_o,
  input  wire logic                 kind_i,
  input  wire logic [VAL_W-1:0]     value_i,
  input  wire logic                 first_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [ROW_W-1:0]   row_q, row_d, cur_row;
  logic [POS_W-1:0]   pos_q, pos_d, cur_pos;
  logic [GRP_W-1:0]   grp_q, grp_d, cur_grp;
  logic [COORD_W-1:0] xbase_q, xbase_d, cur_xbase;
  logic [ADDR_W-1:0]  img_q, img_d, cur_img;
  logic [ADDR_W-1:0]  li_q, li_d, cur_li;
  logic               accept;
  logic               top_half, bot_half, keep;
  logic [COORD_W-1:0] x, y;
  logic [PIX_W-1:0]   pval;

  assign ready_o = !full_i;
  assign accept  = valid_i && !full_i;

  always_comb begin
    cur_row   = first_i ? '0 : row_q;
    cur_pos   = first_i ? '0 : pos_q;
    cur_grp   = first_i ? '0 : grp_q;
    cur_xbase = first_i ? '0 : xbase_q;
    cur_img   = first_i ? '0 : img_q;
    cur_li    = first_i ? '0 : li_q;

    top_half = (cur_row >= ROW_W'(DARK_TOP)) && (cur_row < ROW_W'(DARK_TOP + HALF_ROWS));
    bot_half = (cur_row >= ROW_W'(BOTTOM_START))
            && (cur_row < ROW_W'(BOTTOM_START + HALF_ROWS));
    keep = 1'b0;
    x    = '0;
    y    = '0;
    if (top_half) begin
      keep = cur_pos < POS_W'(IMAGE_WORDS);
      x    = cur_xbase + COORD_W'(cur_pos);
      y    = COORD_W'(cur_row - ROW_W'(DARK_TOP));
    end else if (bot_half) begin
      keep = cur_pos >= POS_W'(INFO_WORDS);
      x    = cur_xbase + COORD_W'(cur_pos) - COORD_W'(INFO_WORDS);
      y    = COORD_W'(cur_row - ROW_W'(DARK_TOP + DARK_MID));
    end

    pval = {value_i[VAL_W-1], value_i};

    row_d   = row_q;
    pos_d   = pos_q;
    grp_d   = grp_q;
    xbase_d = xbase_q;
    img_d   = img_q;
    li_d    = li_q;
    push_o  = 1'b0;
    cmd_o   = '0;

    if (accept) begin
      if (!kind_i) begin
        li_d = cur_li;
        if (cur_li < ADDR_W'(STORE_DEPTH)) begin
          push_o     = 1'b1;
          cmd_o.op   = CmdLoad;
          cmd_o.addr = cur_li;
          cmd_o.data = PED_OFFSET - pval;
          li_d       = cur_li + 1'b1;
        end
      end else begin
        row_d   = cur_row;
        pos_d   = cur_pos;
        grp_d   = cur_grp;
        xbase_d = cur_xbase;
        img_d   = cur_img;
        if (cur_row < ROW_W'(TOTAL_ROWS)) begin
          if (cur_pos == POS_W'(GROUP_WORDS - 1)) begin
            pos_d = '0;
            if (cur_grp == GRP_W'(GROUPS - 1)) begin
              grp_d   = '0;
              xbase_d = '0;
              row_d   = cur_row + 1'b1;
            end else begin
              grp_d   = cur_grp + 1'b1;
              xbase_d = cur_xbase + COORD_W'(IMAGE_WORDS);
            end
          end else begin
            pos_d = cur_pos + 1'b1;
          end
          if (keep && (cur_img < ADDR_W'(STORE_DEPTH))) begin
            push_o     = 1'b1;
            cmd_o.op   = CmdPixel;
            cmd_o.addr = cur_img;
            cmd_o.data = PIX_W'(value_i[RAW_W-1:0]);
            cmd_o.x    = x;
            cmd_o.y    = y;
            cmd_o.last = cur_img == ADDR_W'(STORE_DEPTH - 1);
            img_d      = cur_img + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      pos_q   <= '0;
      grp_q   <= '0;
      xbase_q <= '0;
      img_q   <= '0;
      li_q    <= '0;
    end else begin
      row_q   <= row_d;
      pos_q   <= pos_d;
      grp_q   <= grp_d;
      xbase_q <= xbase_d;
      img_q   <= img_d;
      li_q    <= li_d;
    end
  end

endmodule
`default_nettype wire

### src/cfdp_queue.sv
`default_nettype none
module cfdp_queue
  import cfdp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire cmd_t  cmd_i,
  input  wire logic  pop_i,
  output q_status_t  status_o,
  output cmd_t       cmd_o
);

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign status_o.valid = cnt_q != '0;
  assign status_o.full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && status_o.valid;
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

### src/cfdp_back.sv
`default_nettype none
module cfdp_back
  import cfdp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                use_pedestal_i,
  input  wire logic                q_valid_i,
  input  wire cmd_t                cmd_i,
  output logic                     pop_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output logic [PIX_W-1:0]         pixel_value_o,
  output logic [COORD_W-1:0]       column_o,
  output logic [COORD_W-1:0]       row_o,
  output logic                     pedestal_applied_o,
  output logic                     last_o
);

  localparam int RamAw = $clog2(STORE_DEPTH);

  logic               pop_load, pop_pix, s1_adv;
  logic               s1_valid_q, s1_valid_d;
  logic [RAW_W-1:0]   s1_raw_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q;
  logic               s1_last_q, s1_hit_q;
  logic [ADDR_W-1:0]  fill_q, fill_d;
  logic               out_valid_q, out_valid_d;
  logic [PIX_W-1:0]   ped, rdata, sum_q;
  logic [COORD_W-1:0] col_q, row_q;
  logic               ped_q, last_q;

  // fill_q marks how far the store has ever been loaded; above it the entries
  // were never written, and PED_OFFSET is used as their pedestal instead.
  assign s1_adv   = s1_valid_q && (!out_valid_q || ready_i);
  assign pop_load = q_valid_i && (cmd_i.op == CmdLoad);
  assign pop_pix  = q_valid_i && (cmd_i.op == CmdPixel) && (!s1_valid_q || s1_adv);
  assign pop_o    = pop_load || pop_pix;

  cfdp_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (pop_load),
    .waddr_i (cmd_i.addr[RamAw-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (pop_pix),
    .raddr_i (cmd_i.addr[RamAw-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    fill_d = fill_q;
    if (pop_load && (cmd_i.addr >= fill_q)) begin
      fill_d = cmd_i.addr + 1'b1;
    end
    s1_valid_d = s1_valid_q;
    if (pop_pix) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (ready_i) begin
      out_valid_d = 1'b0;
    end
    if (!use_pedestal_i) begin
      ped = '0;
    end else if (s1_hit_q) begin
      ped = rdata;
    end else begin
      ped = PED_OFFSET;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_pix) begin
      s1_raw_q  <= cmd_i.data[RAW_W-1:0];
      s1_x_q    <= cmd_i.x;
      s1_y_q    <= cmd_i.y;
      s1_last_q <= cmd_i.last;
      s1_hit_q  <= cmd_i.addr < fill_q;
    end
    if (s1_adv) begin
      sum_q  <= PIX_W'(s1_raw_q) + ped;
      col_q  <= s1_x_q;
      row_q  <= s1_y_q;
      ped_q  <= use_pedestal_i;
      last_q <= s1_last_q;
    end
  end

  assign valid_o            = out_valid_q;
  assign pixel_value_o      = sum_q;
  assign column_o           = col_q;
  assign row_o              = row_q;
  assign pedestal_applied_o = ped_q;
  assign last_o             = last_q;

endmodule
`default_nettype wire
